/* rtl/sccr_pkg.sv */
// ----------------------------------------------------------------------------
// sccr_pkg
// Shared types and constants for the sector cache clock replacement block.
// ----------------------------------------------------------------------------
package sccr_pkg;

  localparam int KIND_W          = 2;
  localparam int SECTOR_W        = 32;
  localparam int SLOT_W          = 6;
  localparam int STATUS_W        = 3;
  localparam int DEF_NUM_SLOTS   = 64;
  localparam int DEF_SECTOR_BITS = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FLUSH   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_MISS        = 3'd1,
    ST_ALL_LOCKED  = 3'd2,
    ST_SLOT_LOCKED = 3'd3,
    ST_RELEASED    = 3'd4,
    ST_REL_ERROR   = 3'd5,
    ST_FLUSH_WB    = 3'd6,
    ST_FLUSH_NONE  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACQ,
    S_SCAN,
    S_SWEEP,
    S_INSTALL,
    S_REL,
    S_FLUSH,
    S_FLUSH_RD
  } state_t;

  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_hand;
    logic    cmp_en;
    logic    hand_step;
    logic    emit;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic all_locked;
    logic hit;
    logic hit_locked;
    logic scan_end;
    logic skip;
    logic rel_ok;
    logic any_pending;
    logic pend_cur;
    logic flush_last;
  } stat_t;

endpackage

/* rtl/sccr_ctrl.sv */
// ----------------------------------------------------------------------------
// sccr_ctrl
// Request sequencer: tag scan, clock sweep, install, release and flush walk.
// ----------------------------------------------------------------------------
module sccr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sccr_pkg::KIND_W-1:0] kind,
  input  sccr_pkg::stat_t             stat,
  output sccr_pkg::cmd_t              cmd,
  output logic                        busy
);
  import sccr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_ACQUIRE: state_next = S_ACQ;
            KIND_RELEASE: state_next = S_REL;
            KIND_FLUSH:   state_next = S_FLUSH;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_ACQ: begin
        state_next = stat.all_locked ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.scan_end) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!stat.skip) begin
          state_next = S_INSTALL;
        end
      end
      S_INSTALL: state_next = S_IDLE;
      S_REL:     state_next = S_IDLE;
      S_FLUSH: begin
        if (!stat.any_pending) begin
          state_next = S_IDLE;
        end else if (stat.pend_cur) begin
          state_next = S_FLUSH_RD;
        end
      end
      S_FLUSH_RD: begin
        state_next = stat.flush_last ? S_IDLE : S_FLUSH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_ACQ: begin
        if (stat.all_locked) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_ALL_LOCKED;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.emit   = 1'b1;
          cmd.status = stat.hit_locked ? ST_SLOT_LOCKED : ST_HIT;
        end else if (!stat.scan_end) begin
          cmd.rd_en   = 1'b1;
          cmd.idx_inc = 1'b1;
          cmd.cmp_en  = 1'b1;
        end
      end
      S_SWEEP: begin
        if (stat.skip) begin
          cmd.hand_step = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_hand = 1'b1;
        end
      end
      S_INSTALL: begin
        cmd.emit   = 1'b1;
        cmd.status = ST_MISS;
      end
      S_REL: begin
        cmd.emit   = 1'b1;
        cmd.status = stat.rel_ok ? ST_RELEASED : ST_REL_ERROR;
      end
      S_FLUSH: begin
        if (!stat.any_pending) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_FLUSH_NONE;
        end else if (stat.pend_cur) begin
          cmd.rd_en = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FLUSH_RD: begin
        cmd.emit    = 1'b1;
        cmd.status  = ST_FLUSH_WB;
        cmd.idx_inc = !stat.flush_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/sccr_dp.sv */
// ----------------------------------------------------------------------------
// sccr_dp
// Tag memory, slot flags, clock hand, scan index and result registers.
// ----------------------------------------------------------------------------
module sccr_dp #(
  parameter int NUM_SLOTS   = sccr_pkg::DEF_NUM_SLOTS,
  parameter int SECTOR_BITS = sccr_pkg::DEF_SECTOR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sccr_pkg::cmd_t                cmd,
  output sccr_pkg::stat_t               stat,
  input  logic [sccr_pkg::SECTOR_W-1:0] sector,
  input  logic [sccr_pkg::SLOT_W-1:0]   slot_in,
  input  logic                          mark_dirty,
  output logic                          strobe,
  output logic [sccr_pkg::STATUS_W-1:0] status,
  output logic [sccr_pkg::SLOT_W-1:0]   slot_out,
  output logic                          need_fill,
  output logic                          writeback_valid,
  output logic [sccr_pkg::SECTOR_W-1:0] writeback_sector,
  output logic                          last
);
  import sccr_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int TAG_W = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int EXT_W = SLOT_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [TAG_W-1:0]     tag_mem [NUM_SLOTS];
  logic [TAG_W-1:0]     rd_data;
  logic [IDX_W-1:0]     rd_addr;

  logic [NUM_SLOTS-1:0] valid, dirty, refd, locked;
  logic [NUM_SLOTS-1:0] pending, cur_mask;
  logic [IDX_W-1:0]     hand, hand_inc;
  logic [IDX_W-1:0]     idx, idx_d;
  logic                 cmp_vld;

  logic [TAG_W-1:0]     sec_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 dirty_r;
  logic [EXT_W-1:0]     slot_ext;
  logic [IDX_W-1:0]     rel_idx;
  logic                 rel_in_range;
  logic                 miss_wb;

  assign hand_inc     = (hand == LAST_IDX) ? '0 : hand + 1'b1;
  assign rd_addr      = cmd.rd_hand ? hand : idx;
  assign slot_ext     = EXT_W'(slot_r);
  assign rel_idx      = slot_ext[IDX_W-1:0];
  assign rel_in_range = slot_ext < EXT_W'(NUM_SLOTS);
  assign pending      = valid & dirty & ~locked;
  assign cur_mask     = NUM_SLOTS'(1) << idx;
  assign miss_wb      = valid[hand];

  always_comb begin
    stat             = '0;
    stat.all_locked  = &locked;
    stat.hit         = cmp_vld && valid[idx_d] && (rd_data == sec_r);
    stat.hit_locked  = locked[idx_d];
    stat.scan_end    = cmp_vld && (idx_d == LAST_IDX);
    stat.skip        = refd[hand] || locked[hand];
    stat.rel_ok      = rel_in_range && locked[rel_idx];
    stat.any_pending = |pending;
    stat.pend_cur    = pending[idx];
    stat.flush_last  = ~|(pending & ~cur_mask);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && cmd.status == ST_MISS) begin
      tag_mem[hand] <= sec_r;
    end
    if (cmd.rd_en) begin
      rd_data <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec_r   <= sector[TAG_W-1:0];
      slot_r  <= slot_in;
      dirty_r <= mark_dirty;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    idx_d <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      dirty   <= '0;
      refd    <= '0;
      locked  <= '0;
      hand    <= '0;
      cmp_vld <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      cmp_vld <= cmd.cmp_en;
      strobe  <= cmd.emit;
      if (cmd.hand_step) begin
        refd[hand] <= 1'b0;
        hand       <= hand_inc;
      end
      if (cmd.emit) begin
        case (cmd.status)
          ST_HIT: locked[idx_d] <= 1'b1;
          ST_MISS: begin
            valid[hand]  <= 1'b1;
            dirty[hand]  <= 1'b0;
            locked[hand] <= 1'b1;
            hand         <= hand_inc;
          end
          ST_RELEASED: begin
            if (dirty_r) begin
              dirty[rel_idx] <= 1'b1;
            end
            refd[rel_idx]   <= 1'b1;
            locked[rel_idx] <= 1'b0;
          end
          ST_FLUSH_WB: dirty[idx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status           <= cmd.status;
      need_fill        <= 1'b0;
      writeback_valid  <= 1'b0;
      writeback_sector <= '0;
      slot_out         <= '0;
      last             <= 1'b1;
      case (cmd.status)
        ST_HIT, ST_SLOT_LOCKED: begin
          slot_out <= SLOT_W'(idx_d);
        end
        ST_MISS: begin
          slot_out        <= SLOT_W'(hand);
          need_fill       <= 1'b1;
          writeback_valid <= miss_wb;
          if (miss_wb) begin
            writeback_sector <= SECTOR_W'(rd_data);
          end
        end
        ST_RELEASED, ST_REL_ERROR: begin
          slot_out <= slot_r;
        end
        ST_FLUSH_WB: begin
          slot_out         <= SLOT_W'(idx);
          writeback_valid  <= 1'b1;
          writeback_sector <= SECTOR_W'(rd_data);
          last             <= stat.flush_last;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/sector_cache_clock_replacement.sv */
// A release is answered from the slot flags; acquire scans the tags (one tag read per slot);
// a miss then sweeps the clock hand past referenced or locked slots (under 2*NUM_SLOTS);
// flush walks one slot per cycle, pausing on each slot it writes back (one result each).
// One request at a time: the next one is taken at the edge that ends the last result.
// Each result is registered and shown for one cycle on strobe; the receiver cannot stall.
// Synchronous reset clears all slot flags, the hand and the controller; tags stay unknown.
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement
// Tag and policy controller of a fully associative sector cache using clock
// replacement: acquire, release and flush requests.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement #(
  parameter int NUM_SLOTS   = sccr_pkg::DEF_NUM_SLOTS,
  parameter int SECTOR_BITS = sccr_pkg::DEF_SECTOR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sccr_pkg::KIND_W-1:0]   kind,
  input  logic [sccr_pkg::SECTOR_W-1:0] sector,
  input  logic [sccr_pkg::SLOT_W-1:0]   slot_in,
  input  logic                          mark_dirty,
  output logic                          strobe,
  output logic [sccr_pkg::STATUS_W-1:0] status,
  output logic [sccr_pkg::SLOT_W-1:0]   slot_out,
  output logic                          need_fill,
  output logic                          writeback_valid,
  output logic [sccr_pkg::SECTOR_W-1:0] writeback_sector,
  output logic                          last
);
  import sccr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sccr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sccr_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .sector           (sector),
    .slot_in          (slot_in),
    .mark_dirty       (mark_dirty),
    .strobe           (strobe),
    .status           (status),
    .slot_out         (slot_out),
    .need_fill        (need_fill),
    .writeback_valid  (writeback_valid),
    .writeback_sector (writeback_sector),
    .last             (last)
  );

endmodule
